>>> rtl/bba_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bba_pkg
// Shared types and constants for the buddy block allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

    localparam int DEF_MIN_ORDER = 6;
    localparam int DEF_TOP_ORDER = 16;

    localparam int SIZE_W  = 32;
    localparam int OFF_W   = 16;
    localparam int ORDER_W = 5;
    localparam int HDR_W   = 8;
    localparam int STAT_W  = 2;

    localparam logic [HDR_W-1:0] HDR_RESET = 8'd32;

    localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
    localparam logic [STAT_W-1:0] STAT_OOM     = 2'd1;
    localparam logic [STAT_W-1:0] STAT_INVALID = 2'd2;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_A_ROOT,
        S_A_DESC,
        S_A_DWAIT,
        S_F_CHECK,
        S_MRG,
        S_MRG_WAIT,
        S_UP,
        S_UP_WAIT,
        S_DONE
    } bba_state_t;

endpackage
`default_nettype wire

>>> rtl/bba_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bba_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module bba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

>>> rtl/bba_order.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bba_order
// Rounds a request plus header up to the smallest block order that holds it.
// ----------------------------------------------------------------------------
module bba_order
    import bba_pkg::*;
#(
    parameter int MIN_ORDER = DEF_MIN_ORDER,
    parameter int TOP_ORDER = DEF_TOP_ORDER
) (
    input  wire logic [SIZE_W-1:0]  req_size,
    input  wire logic [HDR_W-1:0]   header_bytes,
    output logic      [ORDER_W-1:0] order,
    output logic                    too_big
);

    logic [SIZE_W:0] need;

    assign need = {1'b0, req_size} + (SIZE_W+1)'(header_bytes);

    // independent compares against each block size, smallest fit wins
    always_comb
    begin
        order = ORDER_W'(TOP_ORDER);
        for (int o = TOP_ORDER; o >= MIN_ORDER; o--)
        begin
            if (need <= ((SIZE_W+1)'(1) << o))
            begin
                order = ORDER_W'(o);
            end
        end
        too_big = need > ((SIZE_W+1)'(1) << TOP_ORDER);
    end

endmodule
`default_nettype wire

>>> rtl/buddy_block_allocator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// buddy_block_allocator
// Binary buddy allocator over a 2^TOP_ORDER byte heap, tree state in RAM.
// ----------------------------------------------------------------------------
// Channel   Dir  Signals                        Content
// s_*       in   s_tvalid/s_tready/s_tuser/s_tdata  kind; req_size, free_offset
// m_*       out  m_tvalid/m_tready/m_tuser/m_tdata  status; block_offset, order
// cfg_*     in   cfg_wr_en/cfg_wr_data             header_bytes
//
// One item at a time. Allocate walks the tree RAM down from the root to the
// granted block, then back up to the root through its single read port.
// Free merges the block with its free buddies, then walks up to the root
// over the same RAM port. Errors end without walking the tree.
// After reset a clearing pass sweeps every address of both
// RAMs; s_tready stays low meanwhile. A stalled result waits in the output
// register; the next item is taken while it waits.
// ----------------------------------------------------------------------------
module buddy_block_allocator
    import bba_pkg::*;
#(
    parameter int MIN_ORDER = DEF_MIN_ORDER,
    parameter int TOP_ORDER = DEF_TOP_ORDER
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire logic             s_tuser,      // [0] kind
    input  wire logic [47:0]      s_tdata,      // [31:0] req_size, [47:32] free_offset
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    output logic [STAT_W-1:0]     m_tuser,      // [1:0] status
    output logic [23:0]           m_tdata,      // [15:0] block_offset, [20:16] block_order
    input  wire logic             cfg_wr_en,
    input  wire logic [HDR_W-1:0] cfg_wr_data
);

    localparam int LEVELS = TOP_ORDER - MIN_ORDER;
    localparam int MASK_W = LEVELS + 1;     // one bit per order in a subtree
    localparam int AW     = LEVELS + 1;     // tree node address
    localparam int NODES  = 1 << AW;
    localparam int UNITS  = 1 << LEVELS;
    localparam int UW     = 1 + ORDER_W;    // allocated flag + order

    localparam logic [MASK_W-1:0] ROOT_MASK = MASK_W'(1) << LEVELS;

    // tree entry: mask of free-block orders present in that subtree
    logic              tree_we;
    logic [AW-1:0]     tree_waddr, tree_raddr;
    logic [MASK_W-1:0] tree_wdata, tree_rdata;
    logic              unit_we;
    logic [LEVELS-1:0] unit_waddr, unit_raddr;
    logic [UW-1:0]     unit_wdata, unit_rdata;

    bba_state_t state_reg, state_next;
    logic [AW-1:0]      clr_reg, clr_next;
    logic [HDR_W-1:0]   hdr_reg, hdr_next;
    logic               free_reg, free_next;
    logic [ORDER_W-1:0] k_reg, k_next;
    logic [ORDER_W-1:0] j_reg, j_next;
    logic [ORDER_W-1:0] o_reg, o_next;
    logic [AW-1:0]      node_reg, node_next;
    logic [MASK_W-1:0]  cur_reg, cur_next;
    logic [LEVELS-1:0]  unit_reg, unit_next;
    logic [STAT_W-1:0]  pst_reg, pst_next;
    logic [OFF_W-1:0]   poff_reg, poff_next;
    logic [ORDER_W-1:0] pord_reg, pord_next;
    logic               mv_reg, mv_next;
    logic [STAT_W-1:0]  mst_reg, mst_next;
    logic [OFF_W-1:0]   moff_reg, moff_next;
    logic [ORDER_W-1:0] mord_reg, mord_next;

    bba_ram #(.WIDTH(MASK_W), .DEPTH(NODES)) u_tree (
        .clk   (clk),
        .we    (tree_we),
        .waddr (tree_waddr),
        .wdata (tree_wdata),
        .raddr (tree_raddr),
        .rdata (tree_rdata)
    );

    bba_ram #(.WIDTH(UW), .DEPTH(UNITS)) u_units (
        .clk   (clk),
        .we    (unit_we),
        .waddr (unit_waddr),
        .wdata (unit_wdata),
        .raddr (unit_raddr),
        .rdata (unit_rdata)
    );

    // request rounding
    logic [ORDER_W-1:0] req_order;
    logic               req_too_big;

    bba_order #(.MIN_ORDER(MIN_ORDER), .TOP_ORDER(TOP_ORDER)) u_order (
        .req_size     (s_tdata[31:0]),
        .header_bytes (hdr_reg),
        .order        (req_order),
        .too_big      (req_too_big)
    );

    // input decode
    logic              acc;
    logic [31:0]       fo32;
    logic              free_bad;
    logic [LEVELS-1:0] in_unit;

    assign acc      = s_tvalid && s_tready;
    assign fo32     = 32'(s_tdata[47:32]);
    assign free_bad = (|(fo32 & ((32'(1) << MIN_ORDER) - 32'(1)))) || (|(fo32 >> TOP_ORDER));
    assign in_unit  = LEVELS'(fo32 >> MIN_ORDER);

    // tree walk helpers
    logic [ORDER_W-1:0] o_idx;
    logic [MASK_W-1:0]  o_bit, j_bit, avail, sib_mask;
    logic               sib_hit, left_has, split, found;
    logic [AW-1:0]      child, sib, fin_node;
    logic [AW-1:0]      cur_top, fin_top;
    logic [LEVELS-1:0]  cur_unit, fin_unit;
    logic [ORDER_W-1:0] pick_ord;
    logic               pick_any;
    logic               u_alloc;
    logic [ORDER_W-1:0] u_ord, u_ord_fix;
    logic [AW-1:0]      free_node;

    assign o_idx    = o_reg - ORDER_W'(MIN_ORDER);
    assign o_bit    = MASK_W'(1) << o_idx;
    assign j_bit    = MASK_W'(1) << (j_reg - ORDER_W'(MIN_ORDER));
    assign sib_hit  = |(tree_rdata & o_bit);
    assign left_has = |(tree_rdata & j_bit);
    assign child    = {node_reg[AW-2:0], 1'b0};
    assign sib      = node_reg ^ AW'(1);
    assign split    = !free_reg && (o_reg < j_reg);
    assign sib_mask = split ? o_bit : tree_rdata;
    assign found    = (o_reg == j_reg);

    // block start (in units) from a node and its order
    assign fin_node = node_reg << (j_reg - k_reg);
    assign cur_top  = AW'(1) << (ORDER_W'(TOP_ORDER) - o_reg);
    assign fin_top  = AW'(1) << (ORDER_W'(TOP_ORDER) - k_reg);
    assign cur_unit = LEVELS'((node_reg & ~cur_top) << o_idx);
    assign fin_unit = LEVELS'((fin_node & ~fin_top) << (k_reg - ORDER_W'(MIN_ORDER)));

    // lowest free order at or above the request, from the root mask
    assign avail = tree_rdata
                   & ~((MASK_W'(1) << (k_reg - ORDER_W'(MIN_ORDER))) - MASK_W'(1));

    always_comb
    begin
        pick_ord = ORDER_W'(TOP_ORDER);
        for (int i = MASK_W - 1; i >= 0; i--)
        begin
            if (avail[i])
            begin
                pick_ord = ORDER_W'(MIN_ORDER + i);
            end
        end
    end
    assign pick_any = |avail;

    // free lookup
    assign u_alloc   = unit_rdata[ORDER_W];
    assign u_ord     = unit_rdata[ORDER_W-1:0];
    assign u_ord_fix = (u_ord < ORDER_W'(MIN_ORDER) || u_ord > ORDER_W'(TOP_ORDER))
                       ? ORDER_W'(MIN_ORDER) : u_ord;
    assign free_node = (AW'(1) << (ORDER_W'(TOP_ORDER) - u_ord_fix))
                       | AW'(unit_reg >> (u_ord_fix - ORDER_W'(MIN_ORDER)));

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:    if (clr_reg == '1) state_next = S_IDLE;
            S_IDLE:
            begin
                if (acc)
                begin
                    if (!s_tuser)
                        state_next = req_too_big ? S_DONE : S_A_ROOT;
                    else
                        state_next = free_bad ? S_DONE : S_F_CHECK;
                end
            end
            S_A_ROOT:   state_next = pick_any ? S_A_DESC : S_DONE;
            S_A_DESC:   state_next = found ? S_UP : S_A_DWAIT;
            S_A_DWAIT:  state_next = S_A_DESC;
            S_F_CHECK:  state_next = u_alloc ? S_MRG : S_DONE;
            S_MRG:      state_next = (o_reg == ORDER_W'(TOP_ORDER)) ? S_UP : S_MRG_WAIT;
            S_MRG_WAIT: state_next = sib_hit ? S_MRG : S_UP;
            S_UP:       state_next = (node_reg == AW'(1)) ? S_DONE : S_UP_WAIT;
            S_UP_WAIT:  state_next = S_UP;
            S_DONE:     if (!mv_reg || m_tready) state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    // memory port control
    always_comb
    begin
        tree_we    = 1'b0;
        tree_waddr = node_reg;
        tree_wdata = cur_reg;
        tree_raddr = AW'(1);
        unit_we    = 1'b0;
        unit_waddr = unit_reg;
        unit_wdata = '0;
        unit_raddr = in_unit;
        unique case (state_reg)
            S_CLEAR:
            begin
                tree_we    = 1'b1;
                tree_waddr = clr_reg;
                tree_wdata = (clr_reg == AW'(1)) ? ROOT_MASK : '0;
                unit_we    = 1'b1;
                unit_waddr = LEVELS'(clr_reg);
            end
            S_A_DESC:
            begin
                if (found)
                begin
                    unit_we    = 1'b1;
                    unit_waddr = fin_unit;
                    unit_wdata = {1'b1, k_reg};
                end
                tree_raddr = child;
            end
            S_F_CHECK:
            begin
                unit_we    = u_alloc;
                unit_wdata = {1'b0, u_ord};
            end
            S_MRG:
            begin
                // node sits inside the growing free block: no free orders below
                tree_we    = (o_reg != ORDER_W'(TOP_ORDER));
                tree_wdata = '0;
                tree_raddr = sib;
            end
            S_MRG_WAIT:
            begin
                tree_we    = sib_hit;
                tree_waddr = sib;
                tree_wdata = '0;
            end
            S_UP:
            begin
                tree_we    = 1'b1;
                tree_raddr = sib;
            end
            S_UP_WAIT:
            begin
                // upper half left over from a split becomes free
                tree_we    = split;
                tree_waddr = sib;
                tree_wdata = o_bit;
            end
            default:
            begin
            end
        endcase
    end

    // datapath registers
    always_comb
    begin
        clr_next  = clr_reg;
        hdr_next  = cfg_wr_en ? cfg_wr_data : hdr_reg;
        free_next = free_reg;
        k_next    = k_reg;
        j_next    = j_reg;
        o_next    = o_reg;
        node_next = node_reg;
        cur_next  = cur_reg;
        unit_next = unit_reg;
        pst_next  = pst_reg;
        poff_next = poff_reg;
        pord_next = pord_reg;
        mv_next   = mv_reg && !m_tready;
        mst_next  = mst_reg;
        moff_next = moff_reg;
        mord_next = mord_reg;
        unique case (state_reg)
            S_CLEAR:    clr_next = clr_reg + AW'(1);
            S_IDLE:
            begin
                free_next = s_tuser;
                k_next    = req_order;
                unit_next = in_unit;
                pst_next  = s_tuser ? STAT_INVALID : STAT_OOM;
                poff_next = '0;
                pord_next = '0;
            end
            S_A_ROOT:
            begin
                j_next    = pick_ord;
                o_next    = ORDER_W'(TOP_ORDER);
                node_next = AW'(1);
            end
            S_A_DESC:
            begin
                if (found)
                begin
                    node_next = fin_node;
                    o_next    = k_reg;
                    cur_next  = '0;
                    pst_next  = STAT_OK;
                    poff_next = OFF_W'({fin_unit, {MIN_ORDER{1'b0}}});
                    pord_next = k_reg;
                end
            end
            S_A_DWAIT:
            begin
                node_next = left_has ? child : (child | AW'(1));
                o_next    = o_reg - ORDER_W'(1);
            end
            S_F_CHECK:
            begin
                o_next    = u_ord_fix;
                node_next = free_node;
            end
            S_MRG:
            begin
                if (o_reg == ORDER_W'(TOP_ORDER))
                begin
                    cur_next  = o_bit;
                    pst_next  = STAT_OK;
                    poff_next = OFF_W'({cur_unit, {MIN_ORDER{1'b0}}});
                    pord_next = o_reg;
                end
            end
            S_MRG_WAIT:
            begin
                if (sib_hit)
                begin
                    node_next = node_reg >> 1;
                    o_next    = o_reg + ORDER_W'(1);
                end
                else
                begin
                    cur_next  = o_bit;
                    pst_next  = STAT_OK;
                    poff_next = OFF_W'({cur_unit, {MIN_ORDER{1'b0}}});
                    pord_next = o_reg;
                end
            end
            S_UP_WAIT:
            begin
                cur_next  = cur_reg | sib_mask;
                node_next = node_reg >> 1;
                o_next    = o_reg + ORDER_W'(1);
            end
            S_DONE:
            begin
                if (!mv_reg || m_tready)
                begin
                    mv_next   = 1'b1;
                    mst_next  = pst_reg;
                    moff_next = poff_reg;
                    mord_next = pord_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            hdr_reg   <= HDR_RESET;
            mv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            hdr_reg   <= hdr_next;
            mv_reg    <= mv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        free_reg <= free_next;
        k_reg    <= k_next;
        j_reg    <= j_next;
        o_reg    <= o_next;
        node_reg <= node_next;
        cur_reg  <= cur_next;
        unit_reg <= unit_next;
        pst_reg  <= pst_next;
        poff_reg <= poff_next;
        pord_reg <= pord_next;
        mst_reg  <= mst_next;
        moff_reg <= moff_next;
        mord_reg <= mord_next;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = mv_reg;
    assign m_tuser  = mst_reg;
    assign m_tdata  = {3'b000, mord_reg, moff_reg};

    // the tree is only written while an item or the clearing pass is in work
    a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |-> !tree_we)
        else $error("tree written while idle");

    // a granted block always has a legal order
    a_ok_order: assert property (@(posedge clk) disable iff (!rst_n)
        (mv_reg && mst_reg == STAT_OK)
        |-> (mord_reg >= ORDER_W'(MIN_ORDER) && mord_reg <= ORDER_W'(TOP_ORDER)))
        else $error("result order out of range");

    // the upward walk never leaves the tree
    a_walk_node: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_UP || state_reg == S_UP_WAIT)
        |-> (node_reg != '0 && o_reg <= ORDER_W'(TOP_ORDER)))
        else $error("tree walk out of range");

endmodule
`default_nettype wire

>>> test/buddy_block_allocator_tb.sv
// ----------------------------------------------------------------------------
// buddy_block_allocator_tb
// Drives allocate and free items into the buddy allocator and compares each
// status, offset and order against a tree-based buddy model kept in the bench.
// ----------------------------------------------------------------------------
module buddy_block_allocator_tb;
    import bba_pkg::*;

    localparam int MIN_O  = DEF_MIN_ORDER;
    localparam int TOP_O  = DEF_TOP_ORDER;
    localparam int UNITS  = 1 << (TOP_O - MIN_O);
    localparam int LIMIT  = 20000;
    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [OFF_W-1:0]   offset;
        logic [ORDER_W-1:0] order;
    } grant_t;

    // heap model and queue of expected grants
    class heap_board;
        bit             free_node[2*UNITS];
        bit             unit_used[UNITS];
        int             unit_ord[UNITS];
        logic [HDR_W-1:0] hdr;
        grant_t         pending[$];
        int             errors;
        int             checked;

        function void clear();
            foreach (free_node[i]) free_node[i] = 0;
            foreach (unit_used[i]) unit_used[i] = 0;
            free_node[1] = 1;
            hdr = HDR_RESET;
            errors = 0;
            checked = 0;
        endfunction

        function grant_t allocate(logic [31:0] size);
            grant_t g;
            longint need;
            int k, j, node, fnd, first;
            need = longint'(size) + longint'(hdr);
            g = '0;
            k = MIN_O;
            fnd = 0;
            node = 0;
            while (k < TOP_O && need > (longint'(1) << k)) k++;
            if (need > (longint'(1) << k)) begin
                g.status = STAT_OOM;
                return g;
            end
            for (j = k; j <= TOP_O && fnd == 0; j++) begin
                first = 1 << (TOP_O - j);
                for (int n = first; n < 2*first && fnd == 0; n++)
                    if (free_node[n]) begin
                        node = n;
                        fnd = 1;
                    end
            end
            if (fnd == 0) begin
                g.status = STAT_OOM;
                return g;
            end
            j--;
            free_node[node] = 0;
            while (j > k) begin
                node = 2*node;
                free_node[node+1] = 1;
                j--;
            end
            g.status = STAT_OK;
            g.offset = OFF_W'((node - (1 << (TOP_O - k))) << k);
            g.order  = ORDER_W'(k);
            unit_used[g.offset >> MIN_O] = 1;
            unit_ord[g.offset >> MIN_O]  = k;
            return g;
        endfunction

        function grant_t release_block(logic [OFF_W-1:0] off);
            grant_t g;
            int u, k, node;
            g = '0;
            g.status = STAT_INVALID;
            if (off % (1 << MIN_O) != 0) return g;
            u = off >> MIN_O;
            if (!unit_used[u]) return g;
            k = unit_ord[u];
            unit_used[u] = 0;
            node = (1 << (TOP_O - k)) + (off >> k);
            while (k < TOP_O && free_node[node ^ 1]) begin
                free_node[node ^ 1] = 0;
                node = node >> 1;
                k++;
            end
            free_node[node] = 1;
            g.status = STAT_OK;
            g.offset = OFF_W'((node - (1 << (TOP_O - k))) << k);
            g.order  = ORDER_W'(k);
            return g;
        endfunction

        function void note_item(logic kind, logic [31:0] size, logic [OFF_W-1:0] off);
            if (kind == KIND_ALLOC) pending.push_back(allocate(size));
            else pending.push_back(release_block(off));
        endfunction

        task report(string what);
            $display("ERROR %s", what);
            errors++;
        endtask

        task check_grant(grant_t got);
            grant_t w;
            checked++;
            if (pending.size() == 0) begin
                report($sformatf("unexpected result %p", got));
                return;
            end
            w = pending.pop_front();
            if (got.status !== w.status)
                report($sformatf("status got %0d want %0d", got.status, w.status));
            if (got.offset !== w.offset)
                report($sformatf("offset got %h want %h", got.offset, w.offset));
            if (got.order !== w.order)
                report($sformatf("order got %0d want %0d", got.order, w.order));
        endtask
    endclass

    logic                clk = 0;
    logic                rst_n = 0;
    logic                s_tvalid = 0;
    logic                s_tready;
    logic                s_tuser = 0;
    logic [47:0]         s_tdata = '0;
    logic                m_tvalid;
    logic                m_tready = 0;
    logic [STAT_W-1:0]   m_tuser;
    logic [23:0]         m_tdata;
    logic                cfg_wr_en = 0;
    logic [HDR_W-1:0]    cfg_wr_data = '0;

    heap_board board;
    int  idle_cycles;
    bit  hold_off;           // long receiver stall request
    bit  stall_pattern_on;
    logic [OFF_W-1:0] live[$];   // offsets currently granted

    buddy_block_allocator DUT (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tuser(s_tuser), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tuser(m_tuser), .m_tdata(m_tdata),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
    );

    always
    begin
        #6 clk = 1;
        #6 clk = 0;
    end

    // receiver: checks and a stall pattern; long hold-off on request
    always @(posedge clk)
    begin
        grant_t got;
        if (m_tvalid && m_tready) begin
            got.status = m_tuser;
            got.offset = m_tdata[15:0];
            got.order  = m_tdata[20:16];
            board.check_grant(got);
        end
        if (hold_off) m_tready <= 1'b0;
        else if (!stall_pattern_on) m_tready <= 1'b1;
        else m_tready <= ($urandom_range(0, 3) != 0);
    end

    // watchdog on accept-free cycles
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > LIMIT) begin
            $display("buddy_block_allocator: mismatch");
            $finish;
        end
    end

    task send_item(logic kind, logic [31:0] size, logic [OFF_W-1:0] off);
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {off, size};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        board.note_item(kind, size, off);
        if (kind == KIND_ALLOC && board.pending[$].status == STAT_OK)
            live.push_back(board.pending[$].offset);
        if (kind == KIND_FREE)
            foreach (live[i]) if (live[i] == off) begin
                live.delete(i);
                break;
            end
    endtask

    task idle_send(int n);
        s_tvalid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    task drain();
        s_tvalid <= 1'b0;
        while (board.pending.size() != 0) @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    task write_header(logic [HDR_W-1:0] v);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        board.hdr = v;
        @(posedge clk);
    endtask

    // random item: mostly sizes that fit, frees of live blocks
    task random_item();
        logic [31:0] size;
        logic [OFF_W-1:0] off;
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) begin
            size = (r < 40) ? $urandom_range(0, 2000) : $urandom;
            if (r == 41) size = $urandom_range(0, 70000);
            send_item(KIND_ALLOC, size, OFF_W'($urandom));
        end else if (r < 90 && live.size() != 0) begin
            off = live[$urandom_range(0, live.size() - 1)];
            send_item(KIND_FREE, $urandom, off);
        end else begin
            off = (r < 95) ? OFF_W'($urandom & 32'hFFC0) : OFF_W'($urandom);
            send_item(KIND_FREE, $urandom, off);
        end
    endtask

    task random_phase(int n);
        int burst;
        while (n > 0) begin
            burst = $urandom_range(1, 12);
            while (burst > 0 && n > 0) begin
                random_item();
                burst--;
                n--;
            end
            if ($urandom_range(0, 2) != 0) idle_send($urandom_range(1, 30));
        end
    endtask

    initial
    begin
        board = new();
        board.clear();
        idle_cycles = 0;
        hold_off = 0;
        stall_pattern_on = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // directed: size extremes, header reset value, merges, bad frees
        send_item(KIND_ALLOC, 32'd0, '0);
        send_item(KIND_ALLOC, 32'd32, '0);
        send_item(KIND_ALLOC, 32'd33, '0);
        send_item(KIND_ALLOC, 32'hFFFF_FFFF, '0);
        send_item(KIND_ALLOC, 32'd65504, '0);
        send_item(KIND_ALLOC, 32'd65505, '0);
        send_item(KIND_FREE, 32'd0, 16'd0);
        send_item(KIND_FREE, 32'd0, 16'd0);      // double free
        send_item(KIND_FREE, 32'd0, 16'd64);
        send_item(KIND_FREE, 32'd0, 16'd128);
        send_item(KIND_FREE, 32'd0, 16'd1);      // misaligned
        send_item(KIND_FREE, 32'd0, 16'hFFFF);
        send_item(KIND_FREE, 32'd0, 16'hFFC0);   // never allocated
        send_item(KIND_ALLOC, 32'd65504, '0);    // whole heap
        send_item(KIND_ALLOC, 32'd1, '0);        // nothing left
        send_item(KIND_FREE, 32'd0, 16'd0);
        drain();

        write_header(8'd0);
        send_item(KIND_ALLOC, 32'd65536, '0);
        send_item(KIND_ALLOC, 32'd65537, '0);
        send_item(KIND_FREE, 32'd0, 16'd0);
        random_phase(150);

        write_header(8'd255);
        send_item(KIND_ALLOC, 32'd65281, '0);
        stall_pattern_on = 1;
        random_phase(250);

        // long receiver hold-off while items keep coming
        fork
            begin
                hold_off = 1;
                repeat (400) @(posedge clk);
                hold_off = 0;
            end
            random_phase(40);
        join
        drain();                                 // sender waits for all results

        write_header(8'd32);
        stall_pattern_on = 0;
        random_phase(200);
        write_header(8'($urandom_range(1, 254)));
        stall_pattern_on = 1;
        random_phase(350);

        drain();
        $display("covered %0d results over four header settings, incl. long output stall",
            board.checked);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("buddy_block_allocator: match");
        else
            $display("buddy_block_allocator: mismatch");
        $finish;
    end
endmodule
